>>> sv/qsd_pkg.sv
`timescale 1ns / 1ps
package qsd_pkg;

  localparam int unsigned MaxBits  = 4;
  localparam int unsigned NumPts   = 1 << MaxBits;
  localparam int unsigned IdxW     = $clog2(NumPts);
  localparam int unsigned LlrLimit = 100;
  localparam int unsigned DistMax  = 2097151;
  localparam logic [2:0]  BpsReset = 3'd2;

  localparam logic [0:0] CfgBps = 1'b0;
  localparam logic [0:0] CfgApr = 1'b1;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeDemap = 1'b1;

  // ln(1+exp(-i/8)) in Q0.8
  function automatic logic [7:0] corr_lut(input logic [5:0] i);
    logic [7:0] r;
    begin
      unique case (i)
        6'd0: r = 8'd177;  6'd1: r = 8'd162;  6'd2: r = 8'd147;  6'd3: r = 8'd134;
        6'd4: r = 8'd121;  6'd5: r = 8'd110;  6'd6: r = 8'd99;   6'd7: r = 8'd89;
        6'd8: r = 8'd80;   6'd9: r = 8'd72;   6'd10: r = 8'd64;  6'd11: r = 8'd58;
        6'd12: r = 8'd52;  6'd13: r = 8'd46;  6'd14: r = 8'd41;  6'd15: r = 8'd37;
        6'd16: r = 8'd32;  6'd17: r = 8'd29;  6'd18: r = 8'd26;  6'd19: r = 8'd23;
        6'd20: r = 8'd20;  6'd21: r = 8'd18;  6'd22: r = 8'd16;  6'd23: r = 8'd14;
        6'd24: r = 8'd12;  6'd25: r = 8'd11;  6'd26: r = 8'd10;  6'd27: r = 8'd9;
        6'd28: r = 8'd8;   6'd29: r = 8'd7;   6'd30: r = 8'd6;   6'd31: r = 8'd5;
        6'd32: r = 8'd5;   6'd33: r = 8'd4;   6'd34: r = 8'd4;   6'd35: r = 8'd3;
        6'd36: r = 8'd3;   6'd37: r = 8'd2;   6'd38: r = 8'd2;   6'd39: r = 8'd2;
        6'd40: r = 8'd2;   6'd41: r = 8'd2;
        6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49: r = 8'd1;
        default: r = 8'd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> sv/qam_soft_demapper.sv
`timescale 1ns / 1ps
// Log-MAP soft demapper over a loaded constellation of up to 16 points.
// A load beat (mode 0) writes one point. A demap beat (mode 1)
// first computes one point metric per cycle through one shared distance
// pipeline, then for each of the n bits folds the 2^n metrics with one
// max* unit, one point per cycle, and presents that bit's LLR. The result
// side can stall the block; the input is stalled throughout a sample.
// Results come MSB first, last marks the final bit.
module qam_soft_demapper
  import qsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [3:0]          point_index_i,
  input  logic signed [15:0]  sample_real_i,
  input  logic signed [15:0]  sample_imag_i,
  input  logic [15:0]         noise_inv_i,
  input  logic signed [15:0]  apri_0_i,
  input  logic signed [15:0]  apri_1_i,
  input  logic signed [15:0]  apri_2_i,
  input  logic signed [15:0]  apri_3_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [2:0]          cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  llr_o,
  output logic [1:0]          bit_position_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    StIdle, StDist, StFold, StOut
  } state_e;

  state_e          state_q;
  logic [2:0]      bps_q;
  logic            apr_q;
  logic [2:0]      n_q;
  logic signed [15:0] yr_q, yi_q;
  logic [15:0]     ninv_q;
  logic signed [15:0] apri_q [MaxBits];
  logic [IdxW:0]   rd_cnt_q;      // read address counter, can hold NumPts
  logic [1:0]      vld_pipe_q;    // read valid, product valid
  logic [IdxW-1:0] wr_idx_q, wr_idx1_q;
  logic [IdxW:0]   pt_q;
  logic [1:0]      bit_q;
  logic signed [22:0] metric_q [NumPts];
  logic signed [24:0] acc_q [2];
  logic [1:0]      have_q;
  logic [34:0]     d2_q;
  logic signed [15:0] llr_q;

  logic            in_acc;
  logic            ram_we;
  logic [15:0]     pr_rd, pi_rd;
  logic [IdxW-1:0] raddr;
  logic [2:0]      n_eff;
  logic [IdxW:0]   npts;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign ram_we      = in_acc && (mode_i == ModeLoad);
  assign raddr       = rd_cnt_q[IdxW-1:0];
  assign npts        = (IdxW+1)'(1) << n_q;

  // clamp bits per symbol
  always_comb begin
    if (bps_q == 3'd0) begin
      n_eff = 3'd1;
    end else if (bps_q > 3'(MaxBits)) begin
      n_eff = 3'(MaxBits);
    end else begin
      n_eff = bps_q;
    end
  end

  qsd_ram #(.Width(16), .Depth(NumPts)) u_ram_re (
    .clk_i, .we_i(ram_we), .waddr_i(point_index_i[IdxW-1:0]),
    .wdata_i(sample_real_i), .raddr_i(raddr), .rdata_o(pr_rd)
  );
  qsd_ram #(.Width(16), .Depth(NumPts)) u_ram_im (
    .clk_i, .we_i(ram_we), .waddr_i(point_index_i[IdxW-1:0]),
    .wdata_i(sample_imag_i), .raddr_i(raddr), .rdata_o(pi_rd)
  );

  // distance: squared sum, then one multiply by noise_inv
  logic signed [16:0] dr, di;
  logic [33:0]        dr2, di2;
  logic [50:0]        prod;
  logic [29:0]        dist_r;
  logic [20:0]        dist_sat;
  always_comb begin
    dr       = 17'(yr_q) - 17'(signed'(pr_rd));
    di       = 17'(yi_q) - 17'(signed'(pi_rd));
    dr2      = 34'(dr * dr);
    di2      = 34'(di * di);
    prod     = 51'(d2_q) * 51'(ninv_q);
    dist_r   = 30'((prod + 51'(1 << 21)) >> 22);
    dist_sat = (dist_r > 30'(DistMax)) ? 21'(DistMax) : dist_r[20:0];
  end

  // fold step: a-priori adjust and max*
  logic [IdxW-1:0]    s;
  logic [1:0]         b;
  logic               sb;
  logic signed [24:0] m, h, a, hi, dd;
  logic [24:0]        diff;
  logic signed [25:0] llr_w;
  logic [2:0]         jj;
  always_comb begin
    h  = '0;
    jj = '0;
    s = pt_q[IdxW-1:0];
    b = 2'(n_q - 3'd1 - 3'(bit_q));
    sb = s[b];
    m = 25'(metric_q[s]);
    if (apr_q) begin
      for (int j = 0; j < MaxBits; j++) begin
        jj = 3'(j);
        if (jj < n_q && 2'(j) != b) begin
          h = 25'(apri_q[2'(n_q - 3'd1 - jj)] >>> 1);
          m = s[j] ? m - h : m + h;
        end
      end
    end
    a    = acc_q[sb];
    hi   = (a > m) ? a : m;
    diff = (a > m) ? 25'(a - m) : 25'(m - a);
    dd   = hi + ((diff < 25'd2048) ? 25'(corr_lut(diff[10:5])) : 25'd0);
    llr_w = 26'(acc_q[0]) - 26'(acc_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bps_q       <= BpsReset;
      apr_q       <= 1'b0;
      out_valid_o <= 1'b0;
      vld_pipe_q  <= '0;
      rd_cnt_q    <= '0;
      have_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgBps) bps_q <= cfg_data_i;
        else apr_q <= cfg_data_i[0];
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc && mode_i == ModeDemap) begin
            state_q  <= StDist;
            n_q      <= n_eff;
            yr_q     <= sample_real_i;
            yi_q     <= sample_imag_i;
            ninv_q   <= noise_inv_i;
            apri_q[0] <= apri_0_i;
            apri_q[1] <= apri_1_i;
            apri_q[2] <= apri_2_i;
            apri_q[3] <= apri_3_i;
            rd_cnt_q <= '0;
            vld_pipe_q <= '0;
          end
        end
        StDist: begin
          // issue reads, square, then scale
          vld_pipe_q <= {vld_pipe_q[0], (rd_cnt_q < npts)};
          if (rd_cnt_q < npts) rd_cnt_q <= rd_cnt_q + 1'b1;
          wr_idx_q  <= raddr;
          if (vld_pipe_q[0]) begin
            d2_q <= 35'(dr2) + 35'(di2);
            wr_idx1_q <= wr_idx_q;
          end
          if (vld_pipe_q[1]) metric_q[wr_idx1_q] <= -23'(dist_sat);
          if (vld_pipe_q[1] && !vld_pipe_q[0] && rd_cnt_q == npts) begin
            state_q <= StFold;
            pt_q    <= '0;
            bit_q   <= '0;
            have_q  <= '0;
          end
        end
        StFold: begin
          if (pt_q == npts) begin
            state_q <= StOut;
            out_valid_o <= 1'b1;
            if (llr_w > $signed(26'(LlrLimit * 256))) llr_q <= 16'(LlrLimit * 256);
            else if (llr_w < -$signed(26'(LlrLimit * 256))) llr_q <= -16'(LlrLimit * 256);
            else llr_q <= llr_w[15:0];
          end else begin
            acc_q[sb]  <= have_q[sb] ? dd : m;
            have_q[sb] <= 1'b1;
            pt_q       <= pt_q + 1'b1;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            if (3'(bit_q) == n_q - 3'd1) begin
              state_q <= StIdle;
            end else begin
              bit_q   <= bit_q + 1'b1;
              pt_q    <= '0;
              have_q  <= '0;
              state_q <= StFold;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign llr_o          = llr_q;
  assign bit_position_o = bit_q;
  assign last_o         = (3'(bit_q) == n_q - 3'd1);

endmodule

>>> sv/qsd_ram.sv
`timescale 1ns / 1ps
module qsd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/qsd_checker.sv
`timescale 1ns / 1ps
module qsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cfg_ready_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [15:0] llr_o,
  input logic [1:0]  bit_position_o,
  input logic        last_o
);

  // result stays while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(llr_o))
    else $error("result dropped under stall");

  // input closed while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o && !cfg_ready_o)
    else $error("input open during output");

  // llr within clip range
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (llr_o <= 16'sd25600) && (llr_o >= -16'sd25600))
    else $error("llr out of range");

  // a non-last beat is followed by a further bit, not idle
  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> in_stall_o)
    else $error("sample ended early");

endmodule

bind qam_soft_demapper qsd_checker u_qsd_checker (.*);
